/* design/yvdb_pkg.sv */
// yvdb_pkg: shared types, constants and helper functions of the yuv delta block decoder
// no dependencies; imported by the interfaces and every module of the block

package yvdb_pkg;

    // fixed field widths
    localparam int GROUP_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int COORD_W    = 10;
    localparam int PIX_W      = 8;
    localparam int PIX_CNT    = 16;
    localparam int MIN_DIM    = 4;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 11'd128;

    // colour conversion arithmetic
    localparam int PROD_W = 21;
    localparam int SUM_W  = 22;
    localparam int FRAC_W = 10;
    localparam logic signed [PROD_W-1:0] K_Y  = 21'sd1192;
    localparam logic signed [PROD_W-1:0] K_RV = 21'sd1634;
    localparam logic signed [PROD_W-1:0] K_GU = 21'sd400;
    localparam logic signed [PROD_W-1:0] K_GV = 21'sd833;
    localparam logic signed [PROD_W-1:0] K_BU = 21'sd2066;
    localparam logic [PIX_W:0] Y_OFFSET = 9'd16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_cfg_reg;

    // delta tables, entries taken modulo 256
    localparam logic [7:0] DELTA_TAB [4][8] = '{
        '{8'h00, 8'h20, 8'h40, 8'h60, 8'h80, 8'hA0, 8'hC0, 8'hE0},
        '{8'h00, 8'h10, 8'h20, 8'h30, 8'hC0, 8'hD0, 8'hE0, 8'hF0},
        '{8'h00, 8'h08, 8'h10, 8'h18, 8'hE0, 8'hE8, 8'hF0, 8'hF8},
        '{8'h00, 8'h04, 8'h08, 8'h0C, 8'hF0, 8'hF4, 8'hF8, 8'hFC}
    };

    // four decoded values of one group, index 0 first
    typedef logic [3:0][7:0] t_grp;

    // one decoded block as it waits in the queue
    typedef struct packed {
        logic [3:0][7:0]  u;
        logic [3:0][7:0]  v;
        logic [15:0][7:0] y;
        logic [7:0]       bx;
        logic [7:0]       by;
        logic             last_frame;
    } t_blk;

    // decode one coded group into its four values
    function automatic t_grp unpack_group(input logic [GROUP_W-1:0] g);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] ts;
        logic [2:0] d1;
        logic [2:0] d2;
        logic [2:0] d3;
        t_grp       v;
        b0 = g[15:8];
        b1 = g[7:0];
        ts = b0[2:1];
        d1 = b1[7:5];
        d2 = b1[4:2];
        d3 = {b1[1:0], b0[0]};
        v[0] = b0 & 8'hF8;
        v[1] = v[0] + DELTA_TAB[ts][d1];
        v[2] = v[1] + DELTA_TAB[ts][d2];
        v[3] = v[2] + DELTA_TAB[ts][d3];
        return v;
    endfunction

    // divide by 1024 toward zero and clamp to a byte
    function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-FRAC_W-1:0] q;
        logic [PIX_W-1:0]        r;
        q = s[SUM_W-1:FRAC_W];
        if (s[SUM_W-1]) begin
            r = '0;
        end else if (q > (SUM_W-FRAC_W)'(255)) begin
            r = '1;
        end else begin
            r = q[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage

/* design/yvdb_in_if.sv */
// yvdb_in_if: valid/ready channel carrying one coded block word
// depends on yvdb_pkg for field widths

interface yvdb_in_if;
    import yvdb_pkg::*;

    logic               valid;
    logic               ready;
    logic [GROUP_W-1:0] u_group;
    logic [GROUP_W-1:0] v_group;
    logic [GROUP_W-1:0] y_group_top_left;
    logic [GROUP_W-1:0] y_group_top_right;
    logic [GROUP_W-1:0] y_group_bottom_left;
    logic [GROUP_W-1:0] y_group_bottom_right;

    modport source (
        output valid, u_group, v_group, y_group_top_left, y_group_top_right,
               y_group_bottom_left, y_group_bottom_right,
        input  ready
    );
    modport sink (
        input  valid, u_group, v_group, y_group_top_left, y_group_top_right,
               y_group_bottom_left, y_group_bottom_right,
        output ready
    );
endinterface

/* design/yvdb_out_if.sv */
// yvdb_out_if: valid/ready channel carrying one decoded pixel word
// depends on yvdb_pkg for field widths

interface yvdb_out_if;
    import yvdb_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic               last_in_block;
    logic               last_in_frame;

    modport source (
        output valid, pixel_x, pixel_y, red, green, blue, last_in_block, last_in_frame,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, red, green, blue, last_in_block, last_in_frame,
        output ready
    );
endinterface

/* design/yvdb_cfg_if.sv */
// yvdb_cfg_if: valid/ready register write channel, index and data
// depends on yvdb_pkg for field widths

interface yvdb_cfg_if;
    import yvdb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/yvdb_front.sv */
// yvdb_front: config registers, group unpacking and block position tracking
// depends on yvdb_pkg, yvdb_in_if and yvdb_cfg_if

module yvdb_front #(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    yvdb_in_if.sink           i_blk,
    yvdb_cfg_if.sink          i_cfg,
    input  logic              i_q_ready,
    output logic              o_q_push,
    output yvdb_pkg::t_blk    o_q_data
);
    import yvdb_pkg::*;

    localparam int BLK_CNT = (MAX_DIMENSION + 3) / 4;
    localparam int BLK_W   = (BLK_CNT > 1) ? $clog2(BLK_CNT) : 1;
    localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
    localparam int LIM_W   = ((CFG_DATA_W > DIM_W) ? CFG_DATA_W : DIM_W) + 1;

    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;
    logic [BLK_W-1:0]      r_col;
    logic [BLK_W-1:0]      r_row;

    logic [LIM_W-1:0] lim_w;
    logic [LIM_W-1:0] lim_h;
    logic [LIM_W-1:0] cols;
    logic [LIM_W-1:0] rows;
    logic             end_row;
    logic             end_frame;
    logic             accept;
    t_grp             gu;
    t_grp             gv;
    t_grp             gy [4];

    assign i_cfg.ready = 1'b1;
    assign i_blk.ready = i_q_ready;
    assign accept      = i_blk.valid && i_q_ready;
    assign o_q_push    = accept;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg.data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // dimensions limited to the legal range, block counts rounded up
    always_comb begin
        lim_w = LIM_W'(r_width);
        if (lim_w < LIM_W'(MIN_DIM)) begin
            lim_w = LIM_W'(MIN_DIM);
        end else if (lim_w > LIM_W'(MAX_DIMENSION)) begin
            lim_w = LIM_W'(MAX_DIMENSION);
        end
        lim_h = LIM_W'(r_height);
        if (lim_h < LIM_W'(MIN_DIM)) begin
            lim_h = LIM_W'(MIN_DIM);
        end else if (lim_h > LIM_W'(MAX_DIMENSION)) begin
            lim_h = LIM_W'(MAX_DIMENSION);
        end
        cols = (lim_w + LIM_W'(3)) >> 2;
        rows = (lim_h + LIM_W'(3)) >> 2;
    end

    // reaches-or-exceeds tests also cover a frame shrunk mid-way
    assign end_row   = (LIM_W'(r_col) + LIM_W'(1)) >= cols;
    assign end_frame = end_row && ((LIM_W'(r_row) + LIM_W'(1)) >= rows);

    // block position advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (end_row) begin
                r_col <= '0;
                r_row <= end_frame ? '0 : BLK_W'(r_row + BLK_W'(1));
            end else begin
                r_col <= BLK_W'(r_col + BLK_W'(1));
            end
        end
    end

    // group decode
    assign gu    = unpack_group(i_blk.u_group);
    assign gv    = unpack_group(i_blk.v_group);
    assign gy[0] = unpack_group(i_blk.y_group_top_left);
    assign gy[1] = unpack_group(i_blk.y_group_top_right);
    assign gy[2] = unpack_group(i_blk.y_group_bottom_left);
    assign gy[3] = unpack_group(i_blk.y_group_bottom_right);

    // reorder luma from sub-block order into raster order
    always_comb begin
        o_q_data.u          = gu;
        o_q_data.v          = gv;
        o_q_data.bx         = 8'(r_col);
        o_q_data.by         = 8'(r_row);
        o_q_data.last_frame = end_frame;
        for (int k = 0; k < PIX_CNT; k++) begin
            o_q_data.y[k] = gy[(k / 8) * 2 + (k % 4) / 2][((k / 4) % 2) * 2 + (k % 2)];
        end
    end

endmodule

/* design/yvdb_queue.sv */
// yvdb_queue: two-deep queue of decoded blocks between front and back
// depends on yvdb_pkg for the block record type

module yvdb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  yvdb_pkg::t_blk i_data,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output yvdb_pkg::t_blk o_head
);
    import yvdb_pkg::*;

    t_blk       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: ;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* design/yvdb_back.sv */
// yvdb_back: pixel sequencer and colour conversion pipeline with output register
// depends on yvdb_pkg and yvdb_out_if

module yvdb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  yvdb_pkg::t_blk i_q_head,
    output logic           o_q_pop,
    yvdb_out_if.source     o_pix
);
    import yvdb_pkg::*;

    logic                      en;
    logic [3:0]                r_k;
    logic [1:0]                quad;

    // stage 1: selected samples
    logic                      r1_v;
    logic signed [PIX_W:0]     r1_c;
    logic signed [PIX_W-1:0]   r1_u;
    logic signed [PIX_W-1:0]   r1_vv;
    logic [COORD_W-1:0]        r1_x;
    logic [COORD_W-1:0]        r1_y;
    logic                      r1_lb;
    logic                      r1_lf;

    // stage 2: products
    logic                      r2_v;
    logic signed [PROD_W-1:0]  r2_yc;
    logic signed [PROD_W-1:0]  r2_rv;
    logic signed [PROD_W-1:0]  r2_gu;
    logic signed [PROD_W-1:0]  r2_gv;
    logic signed [PROD_W-1:0]  r2_bu;
    logic [COORD_W-1:0]        r2_x;
    logic [COORD_W-1:0]        r2_y;
    logic                      r2_lb;
    logic                      r2_lf;

    // output register
    logic                      r_o_v;
    logic [COORD_W-1:0]        r_o_x;
    logic [COORD_W-1:0]        r_o_y;
    logic [PIX_W-1:0]          r_o_r;
    logic [PIX_W-1:0]          r_o_g;
    logic [PIX_W-1:0]          r_o_b;
    logic                      r_o_lb;
    logic                      r_o_lf;

    logic signed [SUM_W-1:0]   sum_r;
    logic signed [SUM_W-1:0]   sum_g;
    logic signed [SUM_W-1:0]   sum_b;

    // whole pipeline moves when the output word is empty or taken
    assign en      = !r_o_v || o_pix.ready;
    assign quad    = {r_k[3], r_k[1]};
    assign o_q_pop = en && i_q_valid && (r_k == 4'd15);

    // pipeline valids and pixel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= 4'd0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r1_v  <= i_q_valid;
            r2_v  <= r1_v;
            r_o_v <= r2_v;
            if (i_q_valid) begin
                r_k <= r_k + 4'd1;
            end
        end
    end

    // sample selection for the current pixel
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_c  <= $signed({1'b0, i_q_head.y[r_k]} - Y_OFFSET);
            r1_u  <= $signed(i_q_head.u[quad]);
            r1_vv <= $signed(i_q_head.v[quad]);
            r1_x  <= {i_q_head.bx, r_k[1:0]};
            r1_y  <= {i_q_head.by, r_k[3:2]};
            r1_lb <= (r_k == 4'd15);
            r1_lf <= (r_k == 4'd15) && i_q_head.last_frame;
        end
    end

    // constant products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_yc <= PROD_W'(r1_c) * K_Y;
            r2_rv <= PROD_W'(r1_vv) * K_RV;
            r2_gu <= PROD_W'(r1_u) * K_GU;
            r2_gv <= PROD_W'(r1_vv) * K_GV;
            r2_bu <= PROD_W'(r1_u) * K_BU;
            r2_x  <= r1_x;
            r2_y  <= r1_y;
            r2_lb <= r1_lb;
            r2_lf <= r1_lf;
        end
    end

    // sums, then scale and clamp into the output word
    assign sum_r = SUM_W'(r2_yc) + SUM_W'(r2_rv);
    assign sum_g = SUM_W'(r2_yc) - SUM_W'(r2_gu) - SUM_W'(r2_gv);
    assign sum_b = SUM_W'(r2_yc) + SUM_W'(r2_bu);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_r  <= clamp_pix(sum_r);
            r_o_g  <= clamp_pix(sum_g);
            r_o_b  <= clamp_pix(sum_b);
            r_o_x  <= r2_x;
            r_o_y  <= r2_y;
            r_o_lb <= r2_lb;
            r_o_lf <= r2_lf;
        end
    end

    assign o_pix.valid         = r_o_v;
    assign o_pix.pixel_x       = r_o_x;
    assign o_pix.pixel_y       = r_o_y;
    assign o_pix.red           = r_o_r;
    assign o_pix.green         = r_o_g;
    assign o_pix.blue          = r_o_b;
    assign o_pix.last_in_block = r_o_lb;
    assign o_pix.last_in_frame = r_o_lf;

endmodule

/* design/yuv_delta_block_decoder.sv */
// yuv_delta_block_decoder: top level of the delta-coded 4x4 yuv block to rgb decoder
// depends on yvdb_pkg, the channel interfaces, yvdb_front, yvdb_queue and yvdb_back

// Each accepted block word (six coded 16-bit groups) yields sixteen RGB pixel words in
// raster order, with image coordinates and end-of-block and end-of-frame flags. The front
// decodes a whole block in the cycle it is accepted and drops it into a two-block queue;
// the back pixel sequencer then issues one pixel per cycle while the output is not held,
// through a three-stage colour conversion pipeline, so the stream is bounded by the single
// pixel output port. On an idle decoder a block's first pixel word leaves the queue through
// the sample, product and output registers. Blocks are accepted while the queue has room,
// so the front keeps taking blocks while the back still drains pixels. Register writes
// (width, height) do not move the block position and are meant for idle periods only.

module yuv_delta_block_decoder #(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    yvdb_in_if.sink    i_blk,
    yvdb_cfg_if.sink   i_cfg,
    yvdb_out_if.source o_pix
);
    import yvdb_pkg::*;

    logic q_push;
    logic q_ready;
    logic q_pop;
    logic q_valid;
    t_blk q_wdata;
    t_blk q_head;

    // block intake and decode
    yvdb_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_blk     (i_blk),
        .i_cfg     (i_cfg),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    // decoded block queue
    yvdb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // pixel sequencing and colour conversion
    yvdb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_pix     (o_pix)
    );

endmodule

/* tb/tb_yuv_delta_block_decoder.sv */
`timescale 1ns / 1ps
// tb_yuv_delta_block_decoder: self-checking bench for the delta-coded yuv block decoder
// depends on yvdb_pkg, the block, config and pixel channel interfaces and the decoder top

module tb_yuv_delta_block_decoder;
    import yvdb_pkg::*;

    localparam int MAX_DIM      = 1024;
    localparam int RUN_LIMIT    = 2_000_000;
    localparam int TAIL_CYCLES  = 20;
    localparam int SHOWN_ERRORS = 10;
    localparam int GAP_PCT      = 61;
    localparam int BOTH_PCT     = 11;

    // colour conversion coefficients, scaled by 1024
    localparam int CY  = 1192;
    localparam int CRV = 1634;
    localparam int CGU = 400;
    localparam int CGV = 833;
    localparam int CBU = 2066;
    localparam int LUMA_BASE = 16;

    // register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // coded groups with flat values: 0x80, 0x78, 248 and 0
    localparam logic [GROUP_W-1:0] UV_MIN = 16'h8000;
    localparam logic [GROUP_W-1:0] UV_MAX = 16'h7800;
    localparam logic [GROUP_W-1:0] Y_TOP  = 16'hF800;
    localparam logic [GROUP_W-1:0] Y_ZERO = 16'h0000;

    // delta steps per table select
    localparam int STEP_TAB [4][8] = '{
        '{0, 32, 64, 96, 128, 160, 192, 224},
        '{0, 16, 32, 48, -64, -48, -32, -16},
        '{0,  8, 16, 24, -32, -24, -16,  -8},
        '{0,  4,  8, 12, -16, -12,  -8,  -4}
    };

    // run phases: frame size, word count; idling follows the phase number
    localparam int PH_N = 10;
    localparam int PH_W [PH_N]     = '{8, 4, 0, 10, 2047, 1024, 1024, 1024, 12, 16};
    localparam int PH_H [PH_N]     = '{8, 4, 3, 6, 2047, 1025, 1024, 1024, 2047, 8};
    localparam int PH_ITEMS [PH_N] = '{30, 20, 15, 30, 52, 52, 52, 52, 20, 15};

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [GROUP_W-1:0] u, v, ytl, ytr, ybl, ybr;
    } t_blk_word;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   r;
        logic [PIX_W-1:0]   g;
        logic [PIX_W-1:0]   b;
        logic               lb;
        logic               lf;
    } t_pix_word;

    typedef logic [3:0][7:0] t_quad;

    logic i_clk = 1'b0;
    logic i_rst_n;

    yvdb_in_if  blk_if ();
    yvdb_cfg_if cfg_if ();
    yvdb_out_if pix_if ();

    yuv_delta_block_decoder #(
        .MAX_DIMENSION(MAX_DIM)
    ) dut (
        .i_clk,
        .i_rst_n,
        .i_blk(blk_if),
        .i_cfg(cfg_if),
        .o_pix(pix_if)
    );

    t_blk_word             blocks_todo [$];
    t_pix_word             pixels_due [$];
    logic [CFG_DATA_W-1:0] frame_w = DIM_RESET;
    logic [CFG_DATA_W-1:0] frame_h = DIM_RESET;
    int unsigned           blk_col = 0;
    int unsigned           blk_row = 0;
    t_idle_mode            idle_mode = IDLE_NONE;
    int                    pixel_errors = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // four values of one coded group, running sum modulo 256
    function automatic t_quad expand_group(input logic [GROUP_W-1:0] grp);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] acc;
        logic [1:0] sel;
        logic [2:0] code [3];
        t_quad      q;
        hi = grp[15:8];
        lo = grp[7:0];
        sel = hi[2:1];
        code[0] = lo[7:5];
        code[1] = lo[4:2];
        code[2] = {lo[1:0], hi[0]};
        acc = hi & 8'hF8;
        q[0] = acc;
        for (int i = 0; i < 3; i++) begin
            acc = acc + 8'(STEP_TAB[sel][code[i]]);
            q[i + 1] = acc;
        end
        return q;
    endfunction

    function automatic logic [GROUP_W-1:0] code_group(input logic [4:0] base,
                                                      input logic [1:0] sel,
                                                      input logic [2:0] d1, d2, d3);
        return {base, sel, d3[0], d1, d2, d3[2:1]};
    endfunction

    function automatic logic [7:0] sat_byte(input int s);
        if (s < 0) return 8'd0;
        if (s > 255) return 8'd255;
        return s[7:0];
    endfunction

    // dimension limited to the legal range, in whole blocks
    function automatic int unsigned blocks_across(input logic [CFG_DATA_W-1:0] d);
        int unsigned n;
        n = d;
        if (n < MIN_DIM) n = MIN_DIM;
        if (n > MAX_DIM) n = MAX_DIM;
        return (n + 3) / 4;
    endfunction

    // sixteen pixel words of one block, then step the block position
    function automatic void decode_block_pixels(input t_blk_word w);
        int unsigned ncols;
        int unsigned nrows;
        bit          row_end;
        bit          frame_end;
        t_quad       uq;
        t_quad       vq;
        t_quad       yq [4];
        int          quad;
        int          sub;
        int          c;
        int          cu;
        int          cv;
        t_pix_word   p;
        ncols = blocks_across(frame_w);
        nrows = blocks_across(frame_h);
        row_end = (blk_col + 1) >= ncols;
        frame_end = row_end && (blk_row + 1) >= nrows;
        uq = expand_group(w.u);
        vq = expand_group(w.v);
        yq[0] = expand_group(w.ytl);
        yq[1] = expand_group(w.ytr);
        yq[2] = expand_group(w.ybl);
        yq[3] = expand_group(w.ybr);
        for (int py = 0; py < 4; py++) begin
            for (int px = 0; px < 4; px++) begin
                quad = (py / 2) * 2 + px / 2;
                sub = (py % 2) * 2 + px % 2;
                c = int'(yq[quad][sub]) - LUMA_BASE;
                cu = int'($signed(uq[quad]));
                cv = int'($signed(vq[quad]));
                p.x = COORD_W'(blk_col * 4 + px);
                p.y = COORD_W'(blk_row * 4 + py);
                p.r = sat_byte((CY * c + CRV * cv) / 1024);
                p.g = sat_byte((CY * c - CGU * cu - CGV * cv) / 1024);
                p.b = sat_byte((CY * c + CBU * cu) / 1024);
                p.lb = (py == 3) && (px == 3);
                p.lf = p.lb && frame_end;
                pixels_due.push_back(p);
            end
        end
        if (row_end) begin
            blk_col = 0;
            blk_row = frame_end ? 0 : blk_row + 1;
        end else begin
            blk_col = blk_col + 1;
        end
    endfunction

    function automatic t_blk_word random_block();
        t_blk_word w;
        w = '0;
        repeat (6) w = {w[5*GROUP_W-1:0], GROUP_W'($urandom)};
        return w;
    endfunction

    function automatic int idle_pct(input bit receiver);
        if (idle_mode == IDLE_BOTH) return BOTH_PCT;
        if (idle_mode == (receiver ? IDLE_RECEIVER : IDLE_SENDER)) return GAP_PCT;
        return 0;
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic void log_error(input string what, input t_pix_word want,
                                      input t_pix_word got);
        if (pixel_errors < SHOWN_ERRORS) begin
            $display("%0t %s: expected x=%0d y=%0d rgb=%02h/%02h/%02h lb=%0b lf=%0b",
                     $time, what, want.x, want.y, want.r, want.g, want.b, want.lb, want.lf);
            $display("%0t %s:      got x=%0d y=%0d rgb=%02h/%02h/%02h lb=%0b lf=%0b",
                     $time, what, got.x, got.y, got.r, got.g, got.b, got.lb, got.lf);
        end
        pixel_errors++;
    endfunction

    // register write, held until the config channel takes it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  frame_w = val;
            REG_IMAGE_HEIGHT: frame_h = val;
            default: ;
        endcase
    endtask

    // wait until every block word is taken and every pixel word is back;
    // checked on the falling edge so the driver's updates have landed
    task automatic settle();
        while (blocks_todo.size() != 0 || blk_if.valid || pixels_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // block word driver, predicts each word as it is accepted
    always @(posedge i_clk) begin : drive_blocks
        t_blk_word w;
        t_blk_word taken;
        if (!i_rst_n) begin
            blk_if.valid <= 1'b0;
        end else begin
            if (blk_if.valid && blk_if.ready) begin
                taken = {blk_if.u_group, blk_if.v_group, blk_if.y_group_top_left,
                         blk_if.y_group_top_right, blk_if.y_group_bottom_left,
                         blk_if.y_group_bottom_right};
                decode_block_pixels(taken);
            end
            if (!blk_if.valid || blk_if.ready) begin
                if (blocks_todo.size() != 0 && !roll(idle_pct(1'b0))) begin
                    w = blocks_todo.pop_front();
                    blk_if.valid                <= 1'b1;
                    blk_if.u_group              <= w.u;
                    blk_if.v_group              <= w.v;
                    blk_if.y_group_top_left     <= w.ytl;
                    blk_if.y_group_top_right    <= w.ytr;
                    blk_if.y_group_bottom_left  <= w.ybl;
                    blk_if.y_group_bottom_right <= w.ybr;
                end else begin
                    blk_if.valid <= 1'b0;
                end
            end
        end
    end

    // pixel word monitor and random back-pressure
    always @(posedge i_clk) begin : check_pixels
        t_pix_word got;
        t_pix_word want;
        if (!i_rst_n) begin
            pix_if.ready <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                got = {pix_if.pixel_x, pix_if.pixel_y, pix_if.red, pix_if.green,
                       pix_if.blue, pix_if.last_in_block, pix_if.last_in_frame};
                if (pixels_due.size() == 0) begin
                    log_error("unexpected pixel word", '0, got);
                end else begin
                    want = pixels_due.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.r !== want.r ||
                        got.g !== want.g || got.b !== want.b || got.lb !== want.lb ||
                        got.lf !== want.lf) begin
                        log_error("pixel mismatch", want, got);
                    end
                end
            end
            pix_if.ready <= !roll(idle_pct(1'b1));
        end
    end

    initial begin : stimulus
        logic [GROUP_W-1:0] g;
        i_rst_n = 1'b0;
        blk_if.valid = 1'b0;
        blk_if.u_group = '0;
        blk_if.v_group = '0;
        blk_if.y_group_top_left = '0;
        blk_if.y_group_top_right = '0;
        blk_if.y_group_bottom_left = '0;
        blk_if.y_group_bottom_right = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        pix_if.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at the reset frame size: all-zero and all-one groups
        idle_mode = IDLE_NONE;
        blocks_todo.push_back({6{16'h0000}});
        blocks_todo.push_back({6{16'hFFFF}});
        // each table select, largest deltas and mixed signs
        for (int s = 0; s < 4; s++) begin
            blocks_todo.push_back({6{code_group(5'h10, 2'(s), 3'd7, 3'd7, 3'd7)}});
            g = code_group(5'h08, 2'(s), 3'd3, 3'd4, 3'd5);
            blocks_todo.push_back({g, g, {4{code_group(5'h04, 2'(s), 3'd1, 3'd6, 3'd2)}}});
        end
        // chroma extremes against dark and bright luma, clamping both ways
        blocks_todo.push_back({UV_MIN, UV_MAX, {4{Y_TOP}}});
        blocks_todo.push_back({UV_MAX, UV_MIN, {4{Y_ZERO}}});
        blocks_todo.push_back({UV_MAX, UV_MAX, {4{Y_TOP}}});
        blocks_todo.push_back({UV_MIN, UV_MIN, {4{Y_ZERO}}});
        blocks_todo.push_back({UV_MIN, UV_MAX, Y_ZERO, Y_TOP, 16'hFFFF, 16'h0000});
        repeat (5) blocks_todo.push_back(random_block());

        // random phases; sizes out of range, odd sizes and frames shrunk mid-way
        for (int i = 0; i < PH_N; i++) begin
            settle();
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(PH_W[i]));
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(PH_H[i]));
            if (i % 4 == 3) begin
                write_reg(REG_SPARE_2, '1);
                write_reg(REG_SPARE_3, 11'd4);
            end
            idle_mode = t_idle_mode'(i % 4);
            repeat (PH_ITEMS[i]) blocks_todo.push_back(random_block());
        end

        settle();
        if (pixel_errors == 0 && pixels_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #RUN_LIMIT;
        $display("FAIL");
        $finish;
    end

endmodule
